// ----- hw/rtl/multi_policy_ready_queue_scheduler_top_assert.svh -----
// assertion macros for the scheduler
`ifndef MULTI_POLICY_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`define MULTI_POLICY_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MPRQ_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// implication whose consequent is checked in the next cycle
`define MPRQ_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ----- hw/rtl/mprq_pkg.sv -----
// ---------------------------------------------------------------------------
// mprq_pkg
// types and constants of the multi-policy ready queue scheduler
// ---------------------------------------------------------------------------
package mprq_pkg;
  localparam int DEFAULT_DEPTH = 16;
  localparam logic [2:0] K_ADD = 3'd0, K_DONE = 3'd1, K_TICK = 3'd2,
                         K_DOWN = 3'd3, K_UP = 3'd4;
  localparam logic [2:0] POL_SJF = 3'd1, POL_PRI = 3'd2, POL_FAST = 3'd4;
  localparam logic [1:0] ADDR_POLICY = 2'd0;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] spd;
    logic [7:0] pri;
  } entry_t;

  // command sent to every cell of a queue in the same cycle
  typedef struct packed {
    logic       push;     // write push_e at tail
    logic       remove;   // delete at rm_pos, shift up
    logic       age;      // decrement priorities
    entry_t     push_e;
  } qcmd_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PICK, S_APPLY, S_OUT} state_t;
endpackage

// ----- hw/rtl/mprq_cell.sv -----
// ---------------------------------------------------------------------------
// mprq_cell
// one queue slot: holds an entry, shifts from its neighbor on removal
// ---------------------------------------------------------------------------
module mprq_cell import mprq_pkg::*; (
  input  logic   clk,
  input  qcmd_t  cmd,
  input  logic   at_tail,    // this slot is the push position
  input  logic   shift,      // at or after the removal point
  input  entry_t from_next,
  output entry_t e
);
  entry_t base;
  always_comb begin
    base = shift ? from_next : e;
    if (cmd.push && at_tail) base = cmd.push_e;
    if (cmd.age && base.pri != 8'd0) base.pri = base.pri - 8'd1;
  end
  always_ff @(posedge clk) begin
    e <= base;
  end
endmodule

// ----- hw/rtl/mprq_queue.sv -----
// ---------------------------------------------------------------------------
// mprq_queue
// chain of cells with a fill count; search result is registered
// ---------------------------------------------------------------------------
module mprq_queue import mprq_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  qcmd_t         cmd,
  input  logic [IW-1:0] rm_pos,
  input  logic [7:0]    find_id,
  output logic          found,
  output logic [IW-1:0] found_pos,
  output entry_t        entries [DEPTH],
  output logic [CW-1:0] used
);
  entry_t nxt [DEPTH];
  logic [DEPTH-1:0] hit;
  logic [IW-1:0] first_pos;
  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_cell
    logic shift, tail;
    assign shift = cmd.remove && (IW'(g) >= rm_pos);
    assign tail = cmd.remove ? (CW'(g) == used - CW'(1)) : (CW'(g) == used);
    if (g == DEPTH - 1) begin : g_end
      assign nxt[g] = entries[g];
    end else begin : g_mid
      assign nxt[g] = entries[g+1];
    end
    mprq_cell u_cell (.clk(clk), .cmd(cmd), .at_tail(tail), .shift(shift),
                      .from_next(nxt[g]), .e(entries[g]));
    assign hit[g] = (CW'(g) < used) && (entries[g].id == find_id);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + CW'(cmd.push) - CW'(cmd.remove);
    end
  end

  // first match
  always_comb begin
    first_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) if (hit[i]) first_pos = IW'(i);
  end

  always_ff @(posedge clk) begin
    found <= |hit;
    found_pos <= first_pos;
  end
endmodule

// ----- hw/rtl/multi_policy_ready_queue_scheduler_top.sv -----
// sequence: a request passes scan, apply and output; a done that leaves ready
// entries also walks them for owner selection (pick) between apply and output
// a new request is accepted only in idle, once the result has been taken, so
// owner selection and output stalls hold off the next request
// reset: synchronous, clears counts, owner and policy; entries stay undefined
// ---------------------------------------------------------------------------
// multi_policy_ready_queue_scheduler_top
// ready/waiting queue scheduler with fifo, fastest and priority policies
// ---------------------------------------------------------------------------
`include "multi_policy_ready_queue_scheduler_top_assert.svh"
module multi_policy_ready_queue_scheduler_top import mprq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_DEPTH,
  localparam int IW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // client_id, speed, priority_req
  input  logic [2:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // owner_id, ready_count, waiting_count, pad
  output logic [1:0]  m_tuser,   // owner_valid, rejected
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [2:0] policy;
  state_t state, state_next;
  logic [2:0] kind;
  entry_t item;
  logic [7:0] owner;
  logic owner_p, rej;
  logic [IW-1:0] best, scan_i;
  qcmd_t rcmd, wcmd;
  logic [IW-1:0] rrm, wrm;
  logic [7:0] rfind;
  logic rfound, wfound;
  logic [IW-1:0] rpos, wpos;
  entry_t rent [QUEUE_DEPTH];
  entry_t went [QUEUE_DEPTH];
  logic [CW-1:0] rused, wused;
  logic pick_do, pick_last;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_POLICY) ? {29'd0, policy} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) policy <= '0;
    else if (psel && penable && pwrite && paddr == ADDR_POLICY) policy <= pwdata[2:0];
  end

  // tick searches for the owner; every other kind searches for the request id
  assign rfind = (kind == K_TICK) ? owner : item.id;

  mprq_queue #(.DEPTH(QUEUE_DEPTH)) u_rq (.clk(clk), .rst(rst), .cmd(rcmd),
    .rm_pos(rrm), .find_id(rfind), .found(rfound), .found_pos(rpos),
    .entries(rent), .used(rused));
  mprq_queue #(.DEPTH(QUEUE_DEPTH)) u_wq (.clk(clk), .rst(rst), .cmd(wcmd),
    .rm_pos(wrm), .find_id(item.id), .found(wfound), .found_pos(wpos),
    .entries(went), .used(wused));

  // done: APPLY removes, then PICK scans the shortened queue (order S_SCAN->
  // S_APPLY->S_PICK->S_OUT); other kinds skip PICK
  assign pick_do = (kind == K_DONE);
  assign pick_last = (CW'(scan_i) + CW'(1) >= rused);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_SCAN;
      S_SCAN:  state_next = S_APPLY;
      S_APPLY: state_next = (pick_do && rused - CW'(rfound) != '0) ? S_PICK : S_OUT;
      S_PICK:  if (pick_last) state_next = S_OUT;
      S_OUT:   if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);

  // queue commands during APPLY, aging at the end of PICK under the priority policy
  always_comb begin
    rcmd = '0; wcmd = '0; rrm = rpos; wrm = wpos;
    rcmd.push_e = item; wcmd.push_e = item;
    if (state == S_APPLY) begin
      unique case (kind)
        K_ADD: rcmd.push = (rused < CW'(QUEUE_DEPTH));
        K_DONE: begin rcmd.remove = rfound; wcmd.remove = wfound; end
        K_TICK: if (rused != '0 && owner_p && rfound) begin
          rcmd.remove = 1'b1; rcmd.push = 1'b1; rcmd.push_e = rent[rpos];
        end
        K_DOWN: if (!wfound && wused < CW'(QUEUE_DEPTH)) begin
          wcmd.push = 1'b1;
          if (rfound) begin rcmd.remove = 1'b1; wcmd.push_e = rent[rpos]; end
        end
        K_UP: if (rused == '0) begin
          wcmd.remove = wfound;
        end else if (!rfound && rused < CW'(QUEUE_DEPTH)) begin
          rcmd.push = 1'b1;
          if (wfound) begin wcmd.remove = 1'b1; rcmd.push_e = went[wpos]; end
        end
        default: ;
      endcase
    end
    if (state == S_PICK && pick_last && policy == POL_PRI) rcmd.age = 1'b1;
  end

  // sequential selection walk, one cell per cycle
  logic better;
  always_comb begin
    if (policy == POL_SJF || policy == POL_FAST) better = rent[scan_i].spd > rent[best].spd;
    else if (policy == POL_PRI) better = rent[scan_i].pri < rent[best].pri;
    else better = 1'b0;
  end
  logic [IW-1:0] best_now;
  assign best_now = better ? scan_i : best;

  always_ff @(posedge clk) begin
    if (rst) begin
      owner <= '0; owner_p <= 1'b0;
    end else if (state == S_APPLY) begin
      unique case (kind)
        K_ADD: if (rused < CW'(QUEUE_DEPTH) && !owner_p) begin
          owner_p <= 1'b1; owner <= item.id;
        end
        K_DONE: if (rused - CW'(rfound) == '0) begin
          owner_p <= 1'b0; owner <= '0;
        end
        K_TICK: if (rused != '0) begin
          owner_p <= 1'b1;
          owner <= (owner_p && rfound && rpos == '0 && rused > CW'(1)) ? rent[1].id
                                                                       : rent[0].id;
        end
        K_UP: if (rused == '0) begin owner_p <= 1'b1; owner <= item.id; end
        default: ;
      endcase
    end else if (state == S_PICK && pick_last) begin
      // last step of pick uses the combined best
      owner_p <= 1'b1; owner <= rent[best_now].id;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      scan_i <= '0; best <= '0;
    end else if (state == S_PICK) begin
      best <= best_now;
      if (!pick_last) scan_i <= scan_i + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind <= s_tuser; item.id <= s_tdata[7:0];
      item.spd <= s_tdata[15:8]; item.pri <= s_tdata[23:16];
    end
    if (state == S_APPLY) begin
      unique case (kind)
        K_ADD:  rej <= (rused >= CW'(QUEUE_DEPTH));
        K_DOWN: rej <= !wfound && wused >= CW'(QUEUE_DEPTH);
        K_UP:   rej <= rused != '0 && !rfound && rused >= CW'(QUEUE_DEPTH);
        default: rej <= 1'b0;
      endcase
    end
  end

  assign m_tdata = {6'd0, 5'(wused), 5'(rused), owner_p ? owner : 8'd0};
  assign m_tuser = {rej, owner_p};

  `MPRQ_ASSERT_IMP(a_cnt, 1'b1, rused <= CW'(QUEUE_DEPTH) && wused <= CW'(QUEUE_DEPTH))
  `MPRQ_ASSERT_IMP(a_own, !owner_p, owner == 8'd0 || state != S_OUT)
  `MPRQ_ASSERT_NXT(a_out, m_tvalid && !m_tready, m_tvalid)
endmodule

// ----- bench/multi_policy_ready_queue_scheduler_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_policy_ready_queue_scheduler_checker
// watches the request, result and register ports of the scheduler, keeps its
// own copy of both queues and the owner, and compares every result in order
// ---------------------------------------------------------------------------
module multi_policy_ready_queue_scheduler_checker import mprq_pkg::*; #(
  parameter int         DEPTH       = DEFAULT_DEPTH,
  parameter logic [1:0] POLICY_ADDR = 2'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // client_id, speed, priority_req
  input  logic [2:0]  s_tuser,   // kind
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // owner_id, ready_count, waiting_count, pad
  input  logic [1:0]  m_tuser,   // owner_valid, rejected
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic       owner_valid;
    logic [7:0] owner_id;
    logic [4:0] ready_count;
    logic [4:0] waiting_count;
    logic       rejected;
  } sched_status_t;

  entry_t        ready_list [DEPTH];
  entry_t        wait_list  [DEPTH];
  int            ready_n, wait_n;
  logic [7:0]    owner;
  logic          has_owner;
  logic [2:0]    policy;
  sched_status_t status_q [$];

  function automatic int find_ready(logic [7:0] id);
    for (int i = 0; i < ready_n; i++)
      if (ready_list[i].id == id) return i;
    return -1;
  endfunction

  function automatic int find_wait(logic [7:0] id);
    for (int i = 0; i < wait_n; i++)
      if (wait_list[i].id == id) return i;
    return -1;
  endfunction

  function automatic void drop_ready(int pos);
    for (int i = pos; i + 1 < ready_n; i++) ready_list[i] = ready_list[i + 1];
    ready_n--;
  endfunction

  function automatic void drop_wait(int pos);
    for (int i = pos; i + 1 < wait_n; i++) wait_list[i] = wait_list[i + 1];
    wait_n--;
  endfunction

  function automatic void choose_owner();
    int best;
    best = 0;
    if (ready_n == 0) begin
      has_owner = 1'b0;
      owner = 8'd0;
      return;
    end
    if (policy == POL_SJF || policy == POL_FAST) begin
      for (int i = 1; i < ready_n; i++)
        if (ready_list[i].spd > ready_list[best].spd) best = i;
    end else if (policy == POL_PRI) begin
      for (int i = 1; i < ready_n; i++)
        if (ready_list[i].pri < ready_list[best].pri) best = i;
    end
    owner = ready_list[best].id;
    has_owner = 1'b1;
    // aging after the choice
    if (policy == POL_PRI)
      for (int i = 0; i < ready_n; i++)
        if (ready_list[i].pri != 8'd0) ready_list[i].pri--;
  endfunction

  function automatic sched_status_t schedule(logic [2:0] kind, entry_t req);
    sched_status_t r;
    entry_t        t;
    int            p;
    logic          rej;
    rej = 1'b0;
    case (kind)
      K_ADD: begin
        if (ready_n >= DEPTH) rej = 1'b1;
        else begin
          ready_list[ready_n++] = req;
          if (!has_owner) begin
            has_owner = 1'b1;
            owner = req.id;
          end
        end
      end
      K_DONE: begin
        p = find_ready(req.id);
        if (p >= 0) drop_ready(p);
        p = find_wait(req.id);
        if (p >= 0) drop_wait(p);
        choose_owner();
      end
      K_TICK: begin
        if (ready_n != 0) begin
          if (has_owner) begin
            p = find_ready(owner);
            if (p >= 0) begin
              t = ready_list[p];
              drop_ready(p);
              ready_list[ready_n++] = t;
            end
          end
          owner = ready_list[0].id;
          has_owner = 1'b1;
        end
      end
      K_DOWN: begin
        if (find_wait(req.id) < 0) begin
          if (wait_n >= DEPTH) rej = 1'b1;
          else begin
            t = req;
            p = find_ready(req.id);
            if (p >= 0) begin
              t = ready_list[p];
              drop_ready(p);
            end
            wait_list[wait_n++] = t;
          end
        end
      end
      K_UP: begin
        if (ready_n == 0) begin
          // empty ready queue: client takes the resource directly
          p = find_wait(req.id);
          if (p >= 0) drop_wait(p);
          owner = req.id;
          has_owner = 1'b1;
        end else if (find_ready(req.id) < 0) begin
          if (ready_n >= DEPTH) rej = 1'b1;
          else begin
            t = req;
            p = find_wait(req.id);
            if (p >= 0) begin
              t = wait_list[p];
              drop_wait(p);
            end
            ready_list[ready_n++] = t;
          end
        end
      end
      default: ;
    endcase
    r.owner_valid   = has_owner;
    r.owner_id      = has_owner ? owner : 8'd0;
    r.ready_count   = 5'(ready_n);
    r.waiting_count = 5'(wait_n);
    r.rejected      = rej;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    sched_status_t exp_s;
    logic [17:0]   exp_data;
    entry_t        req;
    if (rst) begin
      ready_n = 0;
      wait_n = 0;
      owner = 8'd0;
      has_owner = 1'b0;
      policy = 3'd0;
      status_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == POLICY_ADDR)
        policy = pwdata[2:0];
      if (s_tvalid && s_tready) begin
        req.id  = s_tdata[7:0];
        req.spd = s_tdata[15:8];
        req.pri = s_tdata[23:16];
        status_q.push_back(schedule(s_tuser, req));
      end
      if (m_tvalid && m_tready) begin
        if (status_q.size() == 0) begin
          report("results outstanding", 1, 0);
        end else begin
          exp_s = status_q.pop_front();
          // result fields packed from bit 0 up
          exp_data = {exp_s.waiting_count, exp_s.ready_count, exp_s.owner_id};
          if (m_tdata[7:0] !== exp_data[7:0])
            report("owner_id", m_tdata[7:0], exp_data[7:0]);
          if (m_tdata[12:8] !== exp_data[12:8])
            report("ready_count", m_tdata[12:8], exp_data[12:8]);
          if (m_tdata[17:13] !== exp_data[17:13])
            report("waiting_count", m_tdata[17:13], exp_data[17:13]);
          if (m_tuser[0] !== exp_s.owner_valid)
            report("owner_valid", m_tuser[0], exp_s.owner_valid);
          if (m_tuser[1] !== exp_s.rejected)
            report("rejected", m_tuser[1], exp_s.rejected);
        end
      end
    end
    pending = status_q.size();
  end

endmodule

// ----- bench/multi_policy_ready_queue_scheduler_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_policy_ready_queue_scheduler_top_tb
// drives scheduler requests and policy writes with random gaps and stalls;
// a separate checker predicts and compares every result
// ---------------------------------------------------------------------------
module multi_policy_ready_queue_scheduler_top_tb;
  import mprq_pkg::*;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [2:0] POL_FIFO = 3'd0, POL_RR = 3'd3;
  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE = 40;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [23:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          errors, pending, idle_cycles;
  bit          hold_out, rx_free;

  multi_policy_ready_queue_scheduler_top dut (.*);

  multi_policy_ready_queue_scheduler_checker #(.POLICY_ADDR(REG_POLICY)) chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(logic [2:0] kind, logic [7:0] id, logic [7:0] spd,
                              logic [7:0] pri, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {pri, spd, id};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_policy(logic [2:0] pol);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_POLICY; pwdata <= {29'd0, pol};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request(int gap);
    int         r;
    logic [2:0] kind;
    logic [7:0] id;
    r = $urandom_range(0, 99);
    if (r < 34) kind = K_ADD;
    else if (r < 58) kind = K_DONE;
    else if (r < 72) kind = K_TICK;
    else if (r < 86) kind = K_DOWN;
    else kind = K_UP;
    // small id pool so that lookups hit
    id = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 11)) : 8'($urandom);
    send_request(kind, id, 8'($urandom), 8'($urandom), gap);
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  always @(posedge clk) begin
    int r;
    if (rst) m_tready <= 1'b0;
    else if (hold_out) begin
      m_tready <= 1'b0;
      repeat (400) @(posedge clk);
      hold_out = 1'b0;
    end else if (rx_free) m_tready <= 1'b1;
    else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else m_tready <= (r < 70);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [2:0] policies [8];
    policies = '{POL_FIFO, POL_SJF, POL_PRI, POL_RR, POL_FAST, 3'd5, 3'd7, 3'd6};
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_out = 1'b0; rx_free = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_request(K_TICK, 8'd5, 8'd0, 8'd0, 0);      // tick on empty queue
    send_request(K_UP, 8'd200, 8'd1, 8'd1, 0);      // upgrade with ready empty
    send_request(K_DOWN, 8'd9, 8'd255, 8'd255, 1);  // downgrade of unknown id
    send_request(K_DOWN, 8'd9, 8'd3, 8'd3, 0);      // already waiting
    send_request(K_ADD, 8'd0, 8'd0, 8'd255, 0);
    send_request(K_ADD, 8'd255, 8'd255, 8'd0, 0);
    send_request(K_ADD, 8'd0, 8'd7, 8'd7, 0);       // duplicate id
    send_request(K_UP, 8'd255, 8'd0, 8'd0, 0);      // already ready
    send_request(K_UP, 8'd9, 8'd0, 8'd0, 2);        // waiting to ready
    send_request(K_TICK, 8'd0, 8'd0, 8'd0, 0);
    send_request(K_DONE, 8'd77, 8'd0, 8'd0, 0);     // done of absent client
    send_request(K_DONE, 8'd0, 8'd0, 8'd0, 0);
    for (int i = 0; i < 14; i++)                    // fill, last one rejected
      send_request(K_ADD, 8'(30 + i), 8'($urandom), 8'($urandom), 0);
    send_request(K_UP, 8'd150, 8'd9, 8'd9, 0);      // upgrade into full queue
    for (int i = 0; i < 17; i++)                    // waiting fills, then rejects
      send_request(K_DOWN, 8'(100 + i), 8'($urandom), 8'($urandom), 0);
    for (int i = 0; i < 40; i++)
      send_request(K_DONE, 8'($urandom_range(0, 116)), 8'd0, 8'd0, 0);

    for (int ph = 0; ph < 8; ph++) begin
      write_policy(policies[ph]);
      if (ph == 2) hold_out = 1'b1;
      rx_free = (ph == 4);
      for (int i = 0; i < 18; i++)
        send_request(K_ADD, 8'($urandom_range(0, 11)), 8'($urandom), 8'($urandom),
                     (ph == 3) ? pick_gap() : 0);
      for (int i = 0; i < 95; i++)
        random_request((ph == 4 || (i > 40 && i < 60)) ? 0 : pick_gap());
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mprq_pkg.sv
hw/rtl/mprq_cell.sv
hw/rtl/mprq_queue.sv
hw/rtl/multi_policy_ready_queue_scheduler_top.sv
bench/multi_policy_ready_queue_scheduler_checker.sv
bench/multi_policy_ready_queue_scheduler_top_tb.sv
